// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the RTL of the coordinate converter, included by s2c_scale.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define S2C_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Expression must never be true outside reset.
`define S2C_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define S2C_ASSERT(lbl, clk, rstn, prop, msg)
`define S2C_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

// ===== rtl/core/s2c_pkg.sv =====
// Shared constants and types of the spherical to cartesian converter.
package s2c_pkg;

  localparam int unsigned RANGE_BITS_DEF     = 20;
  localparam int unsigned ANGLE_BITS_DEF     = 16;
  localparam int unsigned TRIG_FRAC_BITS_DEF = 16;
  localparam int unsigned INTENSITY_BITS     = 16;

  // CORDIC: 30 micro-rotations in Q2.30 on a 32-bit phase
  localparam int unsigned CORDIC_STAGES = 30;
  localparam int unsigned CORDIC_FRAC   = 30;
  localparam int unsigned XY_BITS       = 33;
  localparam int unsigned PHASE_BITS    = 32;

  localparam logic [XY_BITS-1:0]    CORDIC_GAIN_INV = XY_BITS'(652032874);
  localparam logic [PHASE_BITS-1:0] EIGHTH_TURN     = 32'h2000_0000;

  // arctan(2^-i), 2^32 per turn
  localparam logic [PHASE_BITS-1:0] ATAN_STEPS [CORDIC_STAGES] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
    32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2F,
    32'h000A_2F98, 32'h0005_17CC, 32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA,
    32'h0000_517D, 32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051, 32'h0000_0029,
    32'h0000_0014, 32'h0000_000A, 32'h0000_0005, 32'h0000_0003, 32'h0000_0001
  };

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_90,
    QUAD_180,
    QUAD_270
  } quad_e;

  typedef struct packed {
    logic  vld;
    logic  ok;
    quad_e q_az;
    quad_e q_el;
  } ctrl_t;

  typedef struct packed {
    logic signed [XY_BITS-1:0]    x;
    logic signed [XY_BITS-1:0]    y;
    logic signed [PHASE_BITS-1:0] r;
  } rot_t;

endpackage

// ===== rtl/core/s2c_cordic_cell.sv =====
// One CORDIC micro-rotation cell for azimuth and elevation, with sideband.
module s2c_cordic_cell #(
  parameter int unsigned STAGE      = 0,
  parameter int unsigned RANGE_BITS = s2c_pkg::RANGE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  s2c_pkg::ctrl_t                      ctrl_i,
  input  logic [RANGE_BITS-1:0]               range_i,
  input  logic [s2c_pkg::INTENSITY_BITS-1:0]  intensity_i,
  input  s2c_pkg::rot_t                       az_i,
  input  s2c_pkg::rot_t                       el_i,
  output s2c_pkg::ctrl_t                      ctrl_o,
  output logic [RANGE_BITS-1:0]               range_o,
  output logic [s2c_pkg::INTENSITY_BITS-1:0]  intensity_o,
  output s2c_pkg::rot_t                       az_o,
  output s2c_pkg::rot_t                       el_o
);
  import s2c_pkg::*;

  function automatic rot_t rotate(rot_t v);
    rot_t                      res;
    logic signed [XY_BITS-1:0] dx;
    logic signed [XY_BITS-1:0] dy;
    dx = $signed(v.y) >>> STAGE;
    dy = $signed(v.x) >>> STAGE;
    if (!v.r[PHASE_BITS-1]) begin
      res.x = v.x - dx;
      res.y = v.y + dy;
      res.r = v.r - ATAN_STEPS[STAGE];
    end else begin
      res.x = v.x + dx;
      res.y = v.y - dy;
      res.r = v.r + ATAN_STEPS[STAGE];
    end
    return res;
  endfunction

  ctrl_t                      ctrl_q;
  logic [RANGE_BITS-1:0]      range_q;
  logic [INTENSITY_BITS-1:0]  intensity_q;
  rot_t                       az_d, az_q;
  rot_t                       el_d, el_q;

  assign az_d = rotate(az_i);
  assign el_d = rotate(el_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    range_q     <= range_i;
    intensity_q <= intensity_i;
    az_q        <= az_d;
    el_q        <= el_d;
  end

  assign ctrl_o      = ctrl_q;
  assign range_o     = range_q;
  assign intensity_o = intensity_q;
  assign az_o        = az_q;
  assign el_o        = el_q;

endmodule

// ===== rtl/core/s2c_scale.sv =====
// Trig rounding, quadrant unfolding, range scaling and output register.
`include "assert_macros.svh"

module s2c_scale #(
  parameter int unsigned RANGE_BITS     = s2c_pkg::RANGE_BITS_DEF,
  parameter int unsigned TRIG_FRAC_BITS = s2c_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  s2c_pkg::ctrl_t                      ctrl_i,
  input  logic [RANGE_BITS-1:0]               range_i,
  input  logic [s2c_pkg::INTENSITY_BITS-1:0]  intensity_i,
  input  s2c_pkg::rot_t                       az_i,
  input  s2c_pkg::rot_t                       el_i,
  output logic                                done_o,
  output logic signed [RANGE_BITS:0]          x_pos_o,
  output logic signed [RANGE_BITS:0]          y_pos_o,
  output logic signed [RANGE_BITS:0]          z_pos_o,
  output logic [s2c_pkg::INTENSITY_BITS-1:0]  intensity_out_o,
  output logic                                point_valid_o
);
  import s2c_pkg::*;

  localparam int unsigned SH  = CORDIC_FRAC - TRIG_FRAC_BITS;   // Q30 -> QF
  localparam int unsigned RW  = XY_BITS - SH;                   // rounded CORDIC
  localparam int unsigned TW  = TRIG_FRAC_BITS + 2;             // trig value
  localparam int unsigned HW  = RANGE_BITS + 2;                 // horizontal dist
  localparam int unsigned OW  = RANGE_BITS + 1;                 // coordinate
  localparam int unsigned PW1 = RANGE_BITS + 1 + TW;            // range * trig
  localparam int unsigned PW2 = HW + TW;                        // h * trig
  localparam int unsigned SW  = PW2 - TRIG_FRAC_BITS;           // after shift

  localparam logic signed [RW-1:0]  ONE_R    = RW'(1) << TRIG_FRAC_BITS;
  localparam logic signed [TW-1:0]  TRIG_ONE = TW'(1) << TRIG_FRAC_BITS;
  localparam logic signed [SW-1:0]  LIM_S    = (SW'(1) << RANGE_BITS) - SW'(1);
  localparam logic signed [HW-1:0]  H_MAX    = HW'(1) << RANGE_BITS;
  localparam logic [OW-1:0]         OUT_MIN  = {1'b1, {RANGE_BITS{1'b0}}};

  // round half up to F fraction bits, clamp to +-1
  function automatic logic signed [TW-1:0] round_trig(logic signed [XY_BITS-1:0] v);
    logic signed [XY_BITS-1:0] sum;
    logic signed [RW-1:0]      sh;
    logic signed [RW-1:0]      cl;
    sum = v + $signed(XY_BITS'(1) << (SH - 1));
    sh  = RW'(sum >>> SH);
    if (sh > ONE_R) begin
      cl = ONE_R;
    end else if (sh < -ONE_R) begin
      cl = -ONE_R;
    end else begin
      cl = sh;
    end
    return TW'(cl);
  endfunction

  function automatic logic signed [TW-1:0] quad_cos(quad_e q, logic signed [TW-1:0] cr,
                                                    logic signed [TW-1:0] sr);
    logic signed [TW-1:0] res;
    unique case (q)
      QUAD_0:   res = cr;
      QUAD_90:  res = -sr;
      QUAD_180: res = -cr;
      QUAD_270: res = sr;
      default:  res = cr;
    endcase
    return res;
  endfunction

  function automatic logic signed [TW-1:0] quad_sin(quad_e q, logic signed [TW-1:0] cr,
                                                    logic signed [TW-1:0] sr);
    logic signed [TW-1:0] res;
    unique case (q)
      QUAD_0:   res = sr;
      QUAD_90:  res = cr;
      QUAD_180: res = -sr;
      QUAD_270: res = -cr;
      default:  res = sr;
    endcase
    return res;
  endfunction

  // round half up by F bits, saturate to +-(2^RANGE_BITS - 1)
  function automatic logic signed [OW-1:0] round_sat(logic signed [PW2-1:0] p);
    logic signed [PW2-1:0] sum;
    logic signed [SW-1:0]  sh;
    logic signed [SW-1:0]  cl;
    sum = p + $signed(PW2'(1) << (TRIG_FRAC_BITS - 1));
    sh  = SW'(sum >>> TRIG_FRAC_BITS);
    if (sh > LIM_S) begin
      cl = LIM_S;
    end else if (sh < -LIM_S) begin
      cl = -LIM_S;
    end else begin
      cl = sh;
    end
    return OW'(cl);
  endfunction

  // stage 1: trig values
  ctrl_t                     ctrl1_q;
  logic [RANGE_BITS-1:0]     range1_q;
  logic [INTENSITY_BITS-1:0] int1_q;
  logic signed [TW-1:0]      ca_cr, ca_sr, ce_cr, ce_sr;
  logic signed [TW-1:0]      ca1_d, sa1_d, ce1_d, se1_d;
  logic signed [TW-1:0]      ca1_q, sa1_q, ce1_q, se1_q;

  assign ca_cr = round_trig(az_i.x);
  assign ca_sr = round_trig(az_i.y);
  assign ce_cr = round_trig(el_i.x);
  assign ce_sr = round_trig(el_i.y);
  assign ca1_d = quad_cos(ctrl_i.q_az, ca_cr, ca_sr);
  assign sa1_d = quad_sin(ctrl_i.q_az, ca_cr, ca_sr);
  assign ce1_d = quad_cos(ctrl_i.q_el, ce_cr, ce_sr);
  assign se1_d = quad_sin(ctrl_i.q_el, ce_cr, ce_sr);

  // stage 2: range products
  ctrl_t                     ctrl2_q;
  logic [INTENSITY_BITS-1:0] int2_q;
  logic signed [TW-1:0]      ca2_q, sa2_q;
  logic signed [PW1-1:0]     ph2_d, pz2_d, ph2_q, pz2_q;

  assign ph2_d = $signed({1'b0, range1_q}) * ce1_q;
  assign pz2_d = $signed({1'b0, range1_q}) * se1_q;

  // stage 3: horizontal distance and z
  ctrl_t                     ctrl3_q;
  logic [INTENSITY_BITS-1:0] int3_q;
  logic signed [TW-1:0]      ca3_q, sa3_q;
  logic signed [PW1-1:0]     h_sum;
  logic signed [HW-1:0]      h3_d, h3_q;
  logic signed [OW-1:0]      z3_d, z3_q;

  assign h_sum = ph2_q + $signed(PW1'(1) << (TRIG_FRAC_BITS - 1));
  assign h3_d  = HW'(h_sum >>> TRIG_FRAC_BITS);
  assign z3_d  = round_sat(PW2'(pz2_q));

  // stage 4: horizontal products
  ctrl_t                     ctrl4_q;
  logic [INTENSITY_BITS-1:0] int4_q;
  logic signed [OW-1:0]      z4_q;
  logic signed [PW2-1:0]     px4_d, py4_d, px4_q, py4_q;

  assign px4_d = h3_q * ca3_q;
  assign py4_d = h3_q * sa3_q;

  // stage 5: output register
  logic                      done_q;
  logic                      ok_q;
  logic [INTENSITY_BITS-1:0] int5_q;
  logic signed [OW-1:0]      x5_d, y5_d, z5_d, x5_q, y5_q, z5_q;

  assign x5_d = ctrl4_q.ok ? round_sat(px4_q) : '0;
  assign y5_d = ctrl4_q.ok ? round_sat(py4_q) : '0;
  assign z5_d = ctrl4_q.ok ? z4_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl1_q <= '0;
      ctrl2_q <= '0;
      ctrl3_q <= '0;
      ctrl4_q <= '0;
      done_q  <= 1'b0;
    end else begin
      ctrl1_q <= ctrl_i;
      ctrl2_q <= ctrl1_q;
      ctrl3_q <= ctrl2_q;
      ctrl4_q <= ctrl3_q;
      done_q  <= ctrl4_q.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    range1_q <= range_i;
    int1_q   <= intensity_i;
    ca1_q    <= ca1_d;
    sa1_q    <= sa1_d;
    ce1_q    <= ce1_d;
    se1_q    <= se1_d;

    int2_q   <= int1_q;
    ca2_q    <= ca1_q;
    sa2_q    <= sa1_q;
    ph2_q    <= ph2_d;
    pz2_q    <= pz2_d;

    int3_q   <= int2_q;
    ca3_q    <= ca2_q;
    sa3_q    <= sa2_q;
    h3_q     <= h3_d;
    z3_q     <= z3_d;

    int4_q   <= int3_q;
    z4_q     <= z3_q;
    px4_q    <= px4_d;
    py4_q    <= py4_d;

    ok_q     <= ctrl4_q.ok;
    int5_q   <= int4_q;
    x5_q     <= x5_d;
    y5_q     <= y5_d;
    z5_q     <= z5_d;
  end

  assign done_o          = done_q;
  assign x_pos_o         = x5_q;
  assign y_pos_o         = y5_q;
  assign z_pos_o         = z5_q;
  assign intensity_out_o = int5_q;
  assign point_valid_o   = ok_q;

  `S2C_ASSERT(a_az_trig_bounded, clk_i, rst_ni, ctrl1_q.vld |-> (ca1_q <= TRIG_ONE) && (ca1_q >= -TRIG_ONE) && (sa1_q <= TRIG_ONE) && (sa1_q >= -TRIG_ONE), "azimuth trig value beyond unity")
  `S2C_ASSERT(a_el_trig_bounded, clk_i, rst_ni, ctrl1_q.vld |-> (ce1_q <= TRIG_ONE) && (ce1_q >= -TRIG_ONE) && (se1_q <= TRIG_ONE) && (se1_q >= -TRIG_ONE), "elevation trig value beyond unity")
  `S2C_ASSERT(a_h_bounded, clk_i, rst_ni, ctrl3_q.vld |-> (h3_q <= H_MAX) && (h3_q >= -H_MAX), "horizontal distance exceeds range")
  `S2C_ASSERT(a_invalid_zero, clk_i, rst_ni, (done_q && !ok_q) |-> (x5_q == '0) && (y5_q == '0) && (z5_q == '0), "invalid return with non-zero coordinates")
  `S2C_NEVER(a_no_min_code, clk_i, rst_ni, done_q && ((x5_q == OUT_MIN) || (y5_q == OUT_MIN) || (z5_q == OUT_MIN)), "coordinate outside saturation limit")

endmodule

// ===== rtl/core/spherical_to_cartesian.sv =====
// Top level: lidar return conversion from range/azimuth/elevation to x/y/z.
//
// Converts one lidar return per clock. A transaction is taken on every edge
// where start_i is high; busy_o is never raised, so returns may be streamed
// back to back without gaps. Each result appears on the output ports for
// exactly one cycle with done_o high, after passing through one input
// register, a chain of 30 CORDIC cells (one micro-rotation each, azimuth and
// elevation side by side), then five stages of rounding, quadrant unfolding,
// range multiply and horizontal multiply with saturation. There is no back
// pressure on the result side: the receiver must take each result in the cycle
// it is shown. Results leave in the order the returns came in.
// Angles are binary angles (2^ANGLE_BITS per turn); elevation bits are used
// as they are, negative elevation wraps naturally. Coordinates are rounded
// half up and saturated to +-(2^RANGE_BITS - 1). With range_ok_i low the
// coordinates are zero, point_valid_o is low and intensity still passes.
module spherical_to_cartesian #(
  parameter int unsigned RANGE_BITS     = s2c_pkg::RANGE_BITS_DEF,
  parameter int unsigned ANGLE_BITS     = s2c_pkg::ANGLE_BITS_DEF,
  parameter int unsigned TRIG_FRAC_BITS = s2c_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [RANGE_BITS-1:0]               range_units_i,
  input  logic                                range_ok_i,
  input  logic [ANGLE_BITS-1:0]               azimuth_angle_i,
  input  logic signed [ANGLE_BITS-1:0]        elevation_angle_i,
  input  logic [s2c_pkg::INTENSITY_BITS-1:0]  intensity_in_i,
  output logic                                done_o,
  output logic signed [RANGE_BITS:0]          x_pos_o,
  output logic signed [RANGE_BITS:0]          y_pos_o,
  output logic signed [RANGE_BITS:0]          z_pos_o,
  output logic [s2c_pkg::INTENSITY_BITS-1:0]  intensity_out_o,
  output logic                                point_valid_o
);
  import s2c_pkg::*;

  localparam int unsigned PAD = PHASE_BITS - ANGLE_BITS;

  // fully pipelined, never stalls
  assign busy_o = 1'b0;

  // angle folding to the nearest quadrant: residual lies in +-1/8 turn
  logic [PHASE_BITS-1:0] az_full, el_full, az_bias, el_bias;
  logic [PHASE_BITS-1:0] az_res, el_res;
  ctrl_t                 ctrl0_d;
  rot_t                  az0_d, el0_d;

  assign az_full = {azimuth_angle_i, {PAD{1'b0}}};
  assign el_full = {elevation_angle_i, {PAD{1'b0}}};
  assign az_bias = az_full + EIGHTH_TURN;
  assign el_bias = el_full + EIGHTH_TURN;
  assign az_res  = az_full - {az_bias[PHASE_BITS-1 -: 2], {(PHASE_BITS-2){1'b0}}};
  assign el_res  = el_full - {el_bias[PHASE_BITS-1 -: 2], {(PHASE_BITS-2){1'b0}}};

  always_comb begin
    ctrl0_d.vld  = start_i && !busy_o;
    ctrl0_d.ok   = range_ok_i;
    ctrl0_d.q_az = quad_e'(az_bias[PHASE_BITS-1 -: 2]);
    ctrl0_d.q_el = quad_e'(el_bias[PHASE_BITS-1 -: 2]);
    az0_d.x      = CORDIC_GAIN_INV;
    az0_d.y      = '0;
    az0_d.r      = az_res;
    el0_d.x      = CORDIC_GAIN_INV;
    el0_d.y      = '0;
    el0_d.r      = el_res;
  end

  // input register feeding the cell chain
  ctrl_t                     ctrl_c [CORDIC_STAGES+1];
  logic [RANGE_BITS-1:0]     range_c [CORDIC_STAGES+1];
  logic [INTENSITY_BITS-1:0] int_c [CORDIC_STAGES+1];
  rot_t                      az_c [CORDIC_STAGES+1];
  rot_t                      el_c [CORDIC_STAGES+1];

  ctrl_t                     ctrl0_q;
  logic [RANGE_BITS-1:0]     range0_q;
  logic [INTENSITY_BITS-1:0] int0_q;
  rot_t                      az0_q, el0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl0_q <= '0;
    end else begin
      ctrl0_q <= ctrl0_d;
    end
  end

  always_ff @(posedge clk_i) begin
    range0_q <= range_units_i;
    int0_q   <= intensity_in_i;
    az0_q    <= az0_d;
    el0_q    <= el0_d;
  end

  assign ctrl_c[0]  = ctrl0_q;
  assign range_c[0] = range0_q;
  assign int_c[0]   = int0_q;
  assign az_c[0]    = az0_q;
  assign el_c[0]    = el0_q;

  // one micro-rotation per cell, both angles in lock step
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    s2c_cordic_cell #(
      .STAGE      (i),
      .RANGE_BITS (RANGE_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl_c[i]),
      .range_i     (range_c[i]),
      .intensity_i (int_c[i]),
      .az_i        (az_c[i]),
      .el_i        (el_c[i]),
      .ctrl_o      (ctrl_c[i+1]),
      .range_o     (range_c[i+1]),
      .intensity_o (int_c[i+1]),
      .az_o        (az_c[i+1]),
      .el_o        (el_c[i+1])
    );
  end

  // rounding, unfolding, scaling by range, output register
  s2c_scale #(
    .RANGE_BITS     (RANGE_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_scale (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl_c[CORDIC_STAGES]),
    .range_i         (range_c[CORDIC_STAGES]),
    .intensity_i     (int_c[CORDIC_STAGES]),
    .az_i            (az_c[CORDIC_STAGES]),
    .el_i            (el_c[CORDIC_STAGES]),
    .done_o          (done_o),
    .x_pos_o         (x_pos_o),
    .y_pos_o         (y_pos_o),
    .z_pos_o         (z_pos_o),
    .intensity_out_o (intensity_out_o),
    .point_valid_o   (point_valid_o)
  );

endmodule
